>>> src/pip_pkg.sv
// Shared codes and types for the point-in-polygon winding-number block.
// No dependencies; used by point_in_polygon_winding and tb_top.
package pip_pkg;

    // item function codes; the fourth code is a no-op
    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_APPEND = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;
    localparam logic [1:0] FN_NOP    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic CFG_NORMAL_AXIS = 1'b0;
    localparam logic CFG_ELEVATION   = 1'b1;

    // normal-axis codes
    localparam logic [1:0] AXIS_0       = 2'd0;
    localparam logic [1:0] AXIS_1       = 2'd1;
    localparam logic [1:0] AXIS_2       = 2'd2;
    localparam logic [1:0] AXIS_INVALID = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_LAST   = 8'b0000_0100,
        S_EDGE   = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_ACC    = 8'b0010_0000,
        S_DECIDE = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

endpackage

>>> src/point_in_polygon_winding.sv
// Point-in-polygon test (winding number) over a stored planar polygon.
// Depends on pip_pkg (codes, state type).

// Each input beat clears the polygon, appends one vertex (growing the bounding
// box), queries a 3-D point or, for the no-op code, changes nothing; each gives
// exactly one output beat. Clear, append and the no-op code present their
// output beat in the cycle after acceptance. A query that fails the plane or
// box test goes straight to the output state; otherwise the edge walk reads
// one vertex a cycle from the vertex RAM while no edge straddles the point's v
// coordinate, and each straddling edge holds the walk while it passes through
// the single shared multiplier (two half-width partial products per cross
// product term) plus accumulate and decide.
// No new beat is taken while a query runs. The vertex RAM needs no clearing.
module point_in_polygon_winding #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [COORD_BITS-1:0]                 i_cfg_data,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_func,
    input  logic signed [COORD_BITS-1:0]          i_vertex_u,
    input  logic signed [COORD_BITS-1:0]          i_vertex_v,
    input  logic signed [COORD_BITS-1:0]          i_point_axis0,
    input  logic signed [COORD_BITS-1:0]          i_point_axis1,
    input  logic signed [COORD_BITS-1:0]          i_point_axis2,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_inside_res,
    output logic [$clog2(MAX_VERTICES+1)-1:0]     o_vertex_count,
    output logic [1:0]                            o_status
);

    localparam int W   = COORD_BITS;
    localparam int DW  = COORD_BITS + 1;          // exact coordinate difference
    localparam int H   = DW / 2;                  // low split of multiplier operand
    localparam int PW  = DW + H + 1;              // partial product
    localparam int ACW = 2 * DW;                  // cross-product difference
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int AW  = $clog2(MAX_VERTICES);

    pip_pkg::t_state r_state, n_state;

    logic [1:0]              r_axis;
    logic signed [W-1:0]     r_elev;

    logic [CW-1:0]           r_count, n_count;
    logic signed [W-1:0]     r_umin, r_umax, r_vmin, r_vmax;
    logic signed [W-1:0]     n_umin, n_umax, n_vmin, n_vmax;

    logic signed [W-1:0]     r_x, r_y, r_pn, n_x, n_y, n_pn;
    logic signed [W-1:0]     r_x1, r_y1, n_x1, n_y1;
    logic                    r_start, n_start, r_end, n_end;
    logic [CW-1:0]           r_idx, n_idx;
    logic signed [CW:0]      r_wn, n_wn;
    logic                    r_res, n_res;

    logic signed [DW-1:0]    r_opa, r_opb, r_opc, r_opd;
    logic signed [DW-1:0]    n_opa, n_opb, n_opc, n_opd;
    logic [1:0]              r_step, n_step;
    logic signed [PW-1:0]    r_pp, n_pp;
    logic                    r_pp_vld, r_pp_hi, r_pp_sub;
    logic signed [ACW-1:0]   r_acc, n_acc;

    logic                    r_ovld, n_ovld;
    logic                    r_oinside, n_oinside;
    logic [CW-1:0]           r_ocount, n_ocount;
    logic [1:0]              r_ostatus, n_ostatus;

    // vertex RAM: one write port, one registered read port
    logic signed [W-1:0]     r_mem_u [MAX_VERTICES];
    logic signed [W-1:0]     r_mem_v [MAX_VERTICES];
    logic signed [W-1:0]     r_rd_u, r_rd_v;
    logic                    mem_we;

    logic                    out_free, in_acc;
    logic [CW-1:0]           idx_inc;
    logic                    is_last, hit, endover, crossing, prod_le, outside;

    logic signed [DW-1:0]    mul_a, mul_b;
    logic signed [DW-H-1:0]  mul_b_hi;
    logic signed [H:0]       mul_b_part;
    logic signed [ACW-1:0]   pp_ext, pp_sh;

    function automatic logic signed [DW-1:0] f_diff(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b
    );
        f_diff = DW'(a) - DW'(b);
    endfunction

    function automatic logic [CW-1:0] idx_count_inc(input logic [CW-1:0] c);
        idx_count_inc = c + CW'(1);
    endfunction

    assign out_free   = !r_ovld || !i_out_stall;
    assign o_in_stall = !i_rst_n || !((r_state == pip_pkg::S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid    = r_ovld;
    assign o_inside_res   = r_oinside;
    assign o_vertex_count = r_ocount;
    assign o_status       = r_ostatus;

    assign mem_we = in_acc && (i_func == pip_pkg::FN_APPEND)
                    && (r_count != CW'(MAX_VERTICES));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_u[r_count[AW-1:0]] <= i_vertex_u;
            r_mem_v[r_count[AW-1:0]] <= i_vertex_v;
        end
        r_rd_u <= r_mem_u[n_idx[AW-1:0]];
        r_rd_v <= r_mem_v[n_idx[AW-1:0]];
    end

    // edge tests on the vertex just read (x2,y2) against the previous one
    assign idx_inc = r_idx + CW'(1);
    assign is_last = (idx_inc == r_count);
    assign endover = (r_rd_v >= r_y);
    assign crossing = (r_start != endover);
    assign hit = ((r_rd_u == r_x1) && (r_x1 == r_x)
                  && (((r_y < r_y1) && (r_y > r_rd_v)) || ((r_y > r_y1) && (r_y < r_rd_v))))
              || ((r_rd_v == r_y1) && (r_y1 == r_y)
                  && (((r_x < r_x1) && (r_x > r_rd_u)) || ((r_x > r_x1) && (r_x < r_rd_u))));
    assign outside = (r_pn != r_elev) || (r_x < r_umin) || (r_x > r_umax)
                     || (r_y < r_vmin) || (r_y > r_vmax);

    // shared multiplier: acc = a*b - c*d in four half-width steps
    assign mul_a      = r_step[1] ? r_opc : r_opa;
    assign mul_b      = r_step[1] ? r_opd : r_opb;
    assign mul_b_hi   = mul_b[DW-1:H];
    assign mul_b_part = r_step[0] ? (H+1)'(mul_b_hi) : {1'b0, mul_b[H-1:0]};
    assign n_pp       = PW'(mul_a * mul_b_part);
    assign pp_ext     = ACW'(r_pp);
    assign pp_sh      = r_pp_hi ? (pp_ext <<< H) : pp_ext;
    assign prod_le    = r_acc[ACW-1] || (r_acc == '0);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_umin    = r_umin;
        n_umax    = r_umax;
        n_vmin    = r_vmin;
        n_vmax    = r_vmax;
        n_x       = r_x;
        n_y       = r_y;
        n_pn      = r_pn;
        n_x1      = r_x1;
        n_y1      = r_y1;
        n_start   = r_start;
        n_end     = r_end;
        n_idx     = r_idx;
        n_wn      = r_wn;
        n_res     = r_res;
        n_opa     = r_opa;
        n_opb     = r_opb;
        n_opc     = r_opc;
        n_opd     = r_opd;
        n_step    = r_step;
        n_acc     = r_pp_vld ? (r_pp_sub ? r_acc - pp_sh : r_acc + pp_sh) : r_acc;
        n_ovld    = r_ovld && i_out_stall;
        n_oinside = r_oinside;
        n_ocount  = r_ocount;
        n_ostatus = r_ostatus;

        unique case (r_state)
            pip_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_ovld    = 1'b1;
                    n_oinside = 1'b0;
                    n_ostatus = pip_pkg::ST_OK;
                    n_ocount  = r_count;
                    priority if (i_func == pip_pkg::FN_CLEAR) begin
                        n_count  = '0;
                        n_umin   = '0;
                        n_umax   = '0;
                        n_vmin   = '0;
                        n_vmax   = '0;
                        n_ocount = '0;
                    end else if (i_func == pip_pkg::FN_APPEND) begin
                        if (r_count == CW'(MAX_VERTICES)) begin
                            n_ostatus = pip_pkg::ST_FULL;
                        end else begin
                            if (r_count == '0) begin
                                n_umin = i_vertex_u;
                                n_umax = i_vertex_u;
                                n_vmin = i_vertex_v;
                                n_vmax = i_vertex_v;
                            end else begin
                                if (i_vertex_u < r_umin) n_umin = i_vertex_u;
                                if (i_vertex_u > r_umax) n_umax = i_vertex_u;
                                if (i_vertex_v < r_vmin) n_vmin = i_vertex_v;
                                if (i_vertex_v > r_vmax) n_vmax = i_vertex_v;
                            end
                            n_count  = idx_count_inc(r_count);
                            n_ocount = idx_count_inc(r_count);
                        end
                    end else if (i_func == pip_pkg::FN_QUERY) begin
                        if (r_count == '0) begin
                            n_ostatus = pip_pkg::ST_EMPTY;
                        end else begin
                            n_ovld  = r_ovld && i_out_stall;
                            n_state = pip_pkg::S_CHECK;
                            unique case (r_axis)
                                pip_pkg::AXIS_0: begin
                                    n_pn = i_point_axis0;
                                    n_x  = i_point_axis1;
                                    n_y  = i_point_axis2;
                                end
                                pip_pkg::AXIS_1: begin
                                    n_pn = i_point_axis1;
                                    n_x  = i_point_axis2;
                                    n_y  = i_point_axis0;
                                end
                                default: begin
                                    n_pn = i_point_axis2;
                                    n_x  = i_point_axis0;
                                    n_y  = i_point_axis1;
                                end
                            endcase
                        end
                    end else begin
                        // no-op code: state kept, plain ok beat
                        n_ocount = r_count;
                    end
                end
            end
            pip_pkg::S_CHECK: begin
                n_idx = r_count - CW'(1);
                n_wn  = '0;
                if (outside) begin
                    n_res   = 1'b0;
                    n_state = pip_pkg::S_OUT;
                end else begin
                    n_state = pip_pkg::S_LAST;
                end
            end
            pip_pkg::S_LAST: begin
                // closing edge starts at the last vertex
                n_x1    = r_rd_u;
                n_y1    = r_rd_v;
                n_start = endover;
                n_idx   = '0;
                n_state = pip_pkg::S_EDGE;
            end
            pip_pkg::S_EDGE: begin
                n_end = endover;
                if (hit) begin
                    n_res   = 1'b1;
                    n_state = pip_pkg::S_OUT;
                end else if (crossing) begin
                    n_opa   = f_diff(r_rd_v, r_y);
                    n_opb   = f_diff(r_rd_u, r_x1);
                    n_opc   = f_diff(r_rd_v, r_y1);
                    n_opd   = f_diff(r_rd_u, r_x);
                    n_step  = '0;
                    n_acc   = '0;
                    n_state = pip_pkg::S_MUL;
                end else begin
                    n_x1    = r_rd_u;
                    n_y1    = r_rd_v;
                    n_start = endover;
                    n_idx   = idx_inc;
                    if (is_last) begin
                        n_res   = (r_wn != '0);
                        n_state = pip_pkg::S_OUT;
                    end
                end
            end
            pip_pkg::S_MUL: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) n_state = pip_pkg::S_ACC;
            end
            pip_pkg::S_ACC: begin
                n_state = pip_pkg::S_DECIDE;
            end
            pip_pkg::S_DECIDE: begin
                if (prod_le) begin
                    if (r_end) n_wn = r_wn + (CW+1)'(1);
                end else begin
                    if (!r_end) n_wn = r_wn - (CW+1)'(1);
                end
                n_x1    = r_rd_u;
                n_y1    = r_rd_v;
                n_start = r_end;
                n_idx   = idx_inc;
                if (is_last) begin
                    n_res   = (n_wn != '0);
                    n_state = pip_pkg::S_OUT;
                end else begin
                    n_state = pip_pkg::S_EDGE;
                end
            end
            pip_pkg::S_OUT: begin
                if (out_free) begin
                    n_ovld    = 1'b1;
                    n_oinside = r_res;
                    n_ocount  = r_count;
                    n_ostatus = pip_pkg::ST_OK;
                    n_state   = pip_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pip_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pip_pkg::S_IDLE;
            r_axis   <= pip_pkg::AXIS_0;
            r_elev   <= '0;
            r_count  <= '0;
            r_umin   <= '0;
            r_umax   <= '0;
            r_vmin   <= '0;
            r_vmax   <= '0;
            r_ovld   <= 1'b0;
            r_pp_vld <= 1'b0;
            r_step   <= '0;
            r_idx    <= '0;
            r_wn     <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_umin   <= n_umin;
            r_umax   <= n_umax;
            r_vmin   <= n_vmin;
            r_vmax   <= n_vmax;
            r_ovld   <= n_ovld;
            r_pp_vld <= (r_state == pip_pkg::S_MUL);
            r_step   <= n_step;
            r_idx    <= n_idx;
            r_wn     <= n_wn;
            if (i_cfg_we) begin
                if (i_cfg_idx == pip_pkg::CFG_NORMAL_AXIS) begin
                    if (i_cfg_data[1:0] != pip_pkg::AXIS_INVALID) r_axis <= i_cfg_data[1:0];
                end else begin
                    r_elev <= i_cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_y       <= n_y;
        r_pn      <= n_pn;
        r_x1      <= n_x1;
        r_y1      <= n_y1;
        r_start   <= n_start;
        r_end     <= n_end;
        r_res     <= n_res;
        r_opa     <= n_opa;
        r_opb     <= n_opb;
        r_opc     <= n_opc;
        r_opd     <= n_opd;
        r_pp      <= n_pp;
        r_pp_hi   <= r_step[0];
        r_pp_sub  <= r_step[1];
        r_acc     <= n_acc;
        r_oinside <= n_oinside;
        r_ocount  <= n_ocount;
        r_ostatus <= n_ostatus;
    end

endmodule

>>> test/tb_top.sv
// Self-checking bench for point_in_polygon_winding: scoreboard with its own winding-number
// predictor, directed then random polygon/query traffic, random bursts and output stalls.
// Depends on pip_pkg and point_in_polygon_winding.
`timescale 1ns / 100ps

typedef struct {
    logic       in_poly;
    logic [6:0] count;
    logic [1:0] status;
} t_pip_answer;

class winding_scoreboard;
    localparam int DEPTH = 64;

    int          corner_u [DEPTH];
    int          corner_v [DEPTH];
    int          corners = 0;
    int          u_lo = 0, u_hi = 0, v_lo = 0, v_hi = 0;
    logic [1:0]  axis = pip_pkg::AXIS_0;
    int          elev = 0;
    t_pip_answer expected_answers [$];
    int          failures = 0;

    function void write_reg(logic idx, logic [31:0] data);
        if (idx == pip_pkg::CFG_NORMAL_AXIS) begin
            if (data[1:0] != pip_pkg::AXIS_INVALID) axis = data[1:0];
        end else begin
            elev = data;
        end
    endfunction

    // exact a*b <= c*d; operands reach 33 bits, so 128 bits is ample
    function bit prod_le(longint a, longint b, longint c, longint d);
        logic signed [127:0] lhs, rhs;
        lhs = a;
        lhs = lhs * b;
        rhs = c;
        rhs = rhs * d;
        return lhs <= rhs;
    endfunction

    function bit point_inside(int pt [3]);
        int     ax, ua, va, wn;
        longint x, y, x1, y1, x2, y2;
        bit     start_up, end_up;
        ax = axis;
        ua = (ax + 1) % 3;
        va = (ax + 2) % 3;
        x  = pt[ua];
        y  = pt[va];
        if (pt[ax] != elev) return 0;
        if (x < u_lo || x > u_hi || y < v_lo || y > v_hi) return 0;
        wn = 0;
        // walk starts on the closing edge, last vertex to first
        x1 = corner_u[corners-1];
        y1 = corner_v[corners-1];
        start_up = (y1 >= y);
        for (int i = 0; i < corners; i++) begin
            x2 = corner_u[i];
            y2 = corner_v[i];
            if (x2 == x1 && x1 == x && ((y < y1 && y > y2) || (y > y1 && y < y2))) return 1;
            if (y2 == y1 && y1 == y && ((x < x1 && x > x2) || (x > x1 && x < x2))) return 1;
            end_up = (y2 >= y);
            if (start_up != end_up) begin
                if (prod_le(y2 - y, x2 - x1, y2 - y1, x2 - x)) begin
                    if (end_up) wn++;
                end else begin
                    if (!end_up) wn--;
                end
            end
            start_up = end_up;
            x1 = x2;
            y1 = y2;
        end
        return wn != 0;
    endfunction

    function void note_beat(logic [1:0] fn, logic [31:0] u, logic [31:0] v,
                            logic [31:0] a0, logic [31:0] a1, logic [31:0] a2);
        t_pip_answer ans;
        int          pt [3];
        ans.in_poly = 1'b0;
        ans.status  = pip_pkg::ST_OK;
        case (fn)
            pip_pkg::FN_CLEAR: begin
                corners = 0;
                u_lo = 0; u_hi = 0; v_lo = 0; v_hi = 0;
            end
            pip_pkg::FN_APPEND: begin
                if (corners >= DEPTH) begin
                    ans.status = pip_pkg::ST_FULL;
                end else begin
                    corner_u[corners] = u;
                    corner_v[corners] = v;
                    if (corners == 0) begin
                        u_lo = u; u_hi = u; v_lo = v; v_hi = v;
                    end else begin
                        if (int'(u) < u_lo) u_lo = u;
                        if (int'(u) > u_hi) u_hi = u;
                        if (int'(v) < v_lo) v_lo = v;
                        if (int'(v) > v_hi) v_hi = v;
                    end
                    corners++;
                end
            end
            pip_pkg::FN_QUERY: begin
                if (corners == 0) begin
                    ans.status = pip_pkg::ST_EMPTY;
                end else begin
                    pt[0] = a0;
                    pt[1] = a1;
                    pt[2] = a2;
                    ans.in_poly = point_inside(pt);
                end
            end
            default: ;
        endcase
        ans.count = corners[6:0];
        expected_answers = {expected_answers, ans};
    endfunction

    function void check_beat(logic res_bit, logic [6:0] count, logic [1:0] status);
        t_pip_answer exp_ans;
        if (expected_answers.size() == 0) begin
            $error("output beat with no answer pending");
            failures++;
            return;
        end
        exp_ans = expected_answers.pop_front();
        if (res_bit !== exp_ans.in_poly) begin
            $error("inside_res: expected %0d, got %0d", exp_ans.in_poly, res_bit);
            failures++;
        end
        if (count !== exp_ans.count) begin
            $error("vertex_count: expected %0d, got %0d", exp_ans.count, count);
            failures++;
        end
        if (status !== exp_ans.status) begin
            $error("status: expected %0d, got %0d", exp_ans.status, status);
            failures++;
        end
    endfunction
endclass

module tb_top;

    localparam int  RANDOM_BEATS = 1350;
    localparam int  PHASE_BEATS  = 150;
    localparam logic [31:0] G    = 32'h0001_0000;   // 1.0 in Q16.16

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_idx     = 1'b0;
    logic [31:0] i_cfg_data    = '0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_func        = pip_pkg::FN_CLEAR;
    logic [31:0] i_vertex_u    = '0;
    logic [31:0] i_vertex_v    = '0;
    logic [31:0] i_point_axis0 = '0;
    logic [31:0] i_point_axis1 = '0;
    logic [31:0] i_point_axis2 = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic        o_inside_res;
    logic [6:0]  o_vertex_count;
    logic [1:0]  o_status;

    winding_scoreboard sb;

    int beats_sent = 0;
    int burst_left = 0;
    bit valid_held = 0;
    int stall_mode = 0;
    int stall_left = 0;

    point_in_polygon_winding uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_vertex_u     (i_vertex_u),
        .i_vertex_v     (i_vertex_v),
        .i_point_axis0  (i_point_axis0),
        .i_point_axis1  (i_point_axis1),
        .i_point_axis2  (i_point_axis2),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_inside_res   (o_inside_res),
        .o_vertex_count (o_vertex_count),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    // receiver: check each accepted beat, then pick the next stall level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_beat(o_inside_res, o_vertex_count, o_status);
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 400);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_beat(input logic [1:0] fn, input logic [31:0] u, input logic [31:0] v,
                             input logic [31:0] a0, input logic [31:0] a1,
                             input logic [31:0] a2);
        i_in_valid    <= 1'b1;
        i_func        <= fn;
        i_vertex_u    <= u;
        i_vertex_v    <= v;
        i_point_axis0 <= a0;
        i_point_axis1 <= a1;
        i_point_axis2 <= a2;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_beat(fn, u, v, a0, a1, a2);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
            valid_held = 1;
        end else begin
            i_in_valid <= 1'b0;
            valid_held = 0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 10);
        end
    endtask

    // drop valid and let every pending answer drain before touching registers
    task automatic wait_idle();
        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held = 0;
        end
        while (sb.expected_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [31:0] axis_word, input logic [31:0] elev_word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pip_pkg::CFG_NORMAL_AXIS;
        i_cfg_data <= axis_word;
        @(posedge i_clk);
        sb.write_reg(pip_pkg::CFG_NORMAL_AXIS, axis_word);
        i_cfg_idx  <= pip_pkg::CFG_ELEVATION;
        i_cfg_data <= elev_word;
        @(posedge i_clk);
        sb.write_reg(pip_pkg::CFG_ELEVATION, elev_word);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(input int style);
        int k;
        case (style)
            0: begin
                // coarse grid: plenty of axis-parallel edges and shared coordinates
                k = $urandom_range(0, 12);
                return (k - 6) * int'(G);
            end
            1: begin
                k = $urandom_range(0, 2 * 1048576);
                return k - 1048576;
            end
            2: return $urandom;
            default: begin
                k = $urandom_range(0, 3);
                if (k == 0) return 32'h8000_0000;
                if (k == 1) return 32'h7fff_ffff;
                return $urandom;
            end
        endcase
    endfunction

    function automatic int pick_between(input int lo, input int hi);
        longint          span;
        longint unsigned r;
        span = longint'(hi) - longint'(lo) + 1;
        r    = {$urandom, $urandom};
        return int'(longint'(lo) + longint'(r % span));
    endfunction

    task automatic send_query();
        int          n, i, j, x, y, nrm, ax, kind;
        logic [31:0] pt [3];
        n    = sb.corners;
        ax   = sb.axis;
        kind = (n == 0) ? 9 : $urandom_range(0, 9);
        i    = (n == 0) ? 0 : $urandom_range(0, n - 1);
        j    = (n == 0) ? 0 : (i + 1) % n;
        case (kind)
            0: begin
                x = sb.corner_u[i];
                y = sb.corner_v[i];
            end
            1, 2: begin
                // edge midpoint: strict interior of axis-parallel edges
                x = int'((longint'(sb.corner_u[i]) + sb.corner_u[j]) >>> 1);
                y = int'((longint'(sb.corner_v[i]) + sb.corner_v[j]) >>> 1);
            end
            3, 4, 5: begin
                x = pick_between(sb.u_lo, sb.u_hi);
                y = pick_between(sb.v_lo, sb.v_hi);
            end
            6: begin
                x = sb.corner_u[i];
                y = pick_between(sb.v_lo, sb.v_hi);
            end
            7: begin
                x = pick_between(sb.u_lo, sb.u_hi);
                y = sb.corner_v[i];
            end
            8: begin
                x = sb.corner_u[i] + $urandom_range(0, 2) - 1;
                y = sb.corner_v[i] + $urandom_range(0, 2) - 1;
            end
            default: begin
                x = $urandom;
                y = $urandom;
            end
        endcase
        nrm = sb.elev;
        if ($urandom_range(0, 9) == 0)
            nrm = ($urandom_range(0, 1) == 1) ? nrm + 1 : int'($urandom);
        pt[ax]           = nrm;
        pt[(ax + 1) % 3] = x;
        pt[(ax + 2) % 3] = y;
        send_beat(pip_pkg::FN_QUERY, $urandom, $urandom, pt[0], pt[1], pt[2]);
    endtask

    task automatic run_polygon();
        int n, sel, style, q;
        sel = $urandom_range(0, 99);
        if (sel < 70)      n = $urandom_range(3, 8);
        else if (sel < 80) n = $urandom_range(1, 2);
        else if (sel < 90) n = $urandom_range(9, 20);
        else if (sel < 98) n = $urandom_range(21, 63);
        else               n = $urandom_range(64, 68);   // fills the store; above 64 hits full
        style = $urandom_range(0, 3);
        send_beat(pip_pkg::FN_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        repeat (n)
            send_beat(pip_pkg::FN_APPEND, rand_coord(style), rand_coord(style),
                      $urandom, $urandom, $urandom);
        q = (n > 20) ? $urandom_range(1, 3) : $urandom_range(2, 10);
        repeat (q) send_query();
    endtask

    task automatic run_broken();
        send_beat(pip_pkg::FN_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_query();
        repeat ($urandom_range(0, 2))
            send_beat(pip_pkg::FN_APPEND, rand_coord(1), rand_coord(1),
                      $urandom, $urandom, $urandom);
        send_beat(pip_pkg::FN_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_query();
    endtask

    task automatic run_directed();
        // reset config: normal axis 0, elevation 0, so axis0 is the normal
        send_beat(pip_pkg::FN_QUERY, '0, '0, '0, '0, '0);           // empty store
        send_beat(pip_pkg::FN_NOP, '1, '1, '1, '1, '1);             // unused code
        send_beat(pip_pkg::FN_APPEND, '0, '0, '0, '0, '0);          // first vertex
        send_beat(pip_pkg::FN_QUERY, '0, '0, '0, '0, '0);           // single vertex
        send_beat(pip_pkg::FN_APPEND, 4 * G, '0, '0, '0, '0);
        send_beat(pip_pkg::FN_APPEND, 4 * G, 4 * G, '0, '0, '0);
        send_beat(pip_pkg::FN_APPEND, '0, 4 * G, '0, '0, '0);
        send_beat(pip_pkg::FN_QUERY, '0, '0, '0, 2 * G, 2 * G);     // interior
        send_beat(pip_pkg::FN_QUERY, '0, '0, '0, 2 * G, '0);        // on a flat edge
        send_beat(pip_pkg::FN_QUERY, '0, '0, '0, '0, 2 * G);        // on an upright edge
        send_beat(pip_pkg::FN_QUERY, '0, '0, '0, 4 * G, 4 * G);     // on a corner
        send_beat(pip_pkg::FN_QUERY, '0, '0, '0, 5 * G, 2 * G);     // outside the box
        send_beat(pip_pkg::FN_QUERY, '0, '0, 32'd1, 2 * G, 2 * G);  // off the plane
        send_beat(pip_pkg::FN_CLEAR, '1, '1, '1, '1, '1);
        send_beat(pip_pkg::FN_APPEND, 32'h8000_0000, 32'h8000_0000, '1, '1, '1);
        send_beat(pip_pkg::FN_APPEND, 32'h7fff_ffff, 32'h8000_0000, '0, '0, '0);
        send_beat(pip_pkg::FN_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, '1, '1, '1);
        send_beat(pip_pkg::FN_APPEND, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0);
        send_beat(pip_pkg::FN_QUERY, '1, '1, '0, '0, '0);
        send_beat(pip_pkg::FN_QUERY, '0, '0, '0, 32'h7fff_ffff, '0);
        send_beat(pip_pkg::FN_QUERY, '0, '0, '0, 32'h8000_0000, 32'h8000_0000);
        send_beat(pip_pkg::FN_QUERY, '0, '0, '1, '1, '1);
        send_beat(pip_pkg::FN_CLEAR, '0, '0, '0, '0, '0);
        send_beat(pip_pkg::FN_QUERY, '1, '1, '1, '1, '1);
    endtask

    initial begin
        int          phase, next_cfg, guard, sel;
        logic [31:0] axis_word, elev_word;
        sb = new;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        phase    = 0;
        next_cfg = beats_sent;
        while (beats_sent < RANDOM_BEATS + 24) begin
            if (beats_sent >= next_cfg) begin
                wait_idle();
                axis_word = $urandom;
                // the first four phases walk the axis codes, the invalid one included
                axis_word[1:0] = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
                case (phase)
                    0:       elev_word = 32'h7fff_ffff;
                    1:       elev_word = 32'h8000_0000;
                    2:       elev_word = '0;
                    3:       elev_word = G;
                    default: elev_word = ($urandom_range(0, 1) == 1) ? $urandom
                                                                      : rand_coord(3);
                endcase
                reconfigure(axis_word, elev_word);
                phase++;
                next_cfg = beats_sent + PHASE_BEATS;
            end
            sel = $urandom_range(0, 99);
            if (sel < 80)
                run_polygon();
            else if (sel < 92)
                send_beat(2'($urandom_range(0, 3)), $urandom, $urandom,
                          $urandom, $urandom, $urandom);
            else
                run_broken();
        end

        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held = 0;
        end
        guard = 0;
        while (sb.expected_answers.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.expected_answers.size() != 0) begin
            $error("%0d answers never arrived", sb.expected_answers.size());
            sb.failures++;
        end

        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
src/pip_pkg.sv
src/point_in_polygon_winding.sv
test/tb_top.sv
